[hw/rtl/cuw_pkg.sv]
// ----------------------------------------------------------------------------
// cuw_pkg: shared types and constants for correspondence inlier weighting
// Field widths, register indexes, the queue entry and the logistic table.
// ----------------------------------------------------------------------------
`default_nettype none

package cuw_pkg;

	localparam int COMPONENT_BITS    = 16;
	localparam int COUNT_BITS        = 20;
	localparam int EXP_TABLE_ENTRIES = 256;

	localparam int FIELD_W   = 48;
	localparam int FLAG_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES);

	localparam int DIFF_W = COMPONENT_BITS + 1;
	localparam int SQ_W   = 2 * COMPONENT_BITS;
	localparam int D2_W   = SQ_W + 3;
	localparam int PROD_W = D2_W + FLAG_W;
	localparam int DOT_W  = 2 * COMPONENT_BITS + 2;

	localparam int SUM_W  = 64;
	localparam int WT_W   = 40;
	localparam int INV_W  = 32;
	localparam int CNT_W  = COUNT_BITS + 1;
	localparam int ORI_W  = 40;
	localparam int HALF_W = INV_W / 2;
	localparam int PP_W   = D2_W + HALF_W;
	localparam int ZP_W   = D2_W + INV_W;
	localparam int Z_SHIFT = 31;
	localparam int Z_W    = SUM_W - Z_SHIFT;
	localparam int K2_W   = 24;
	localparam int MAG_W  = Z_W - 1;
	localparam int ARG_W  = 20;
	localparam int LIM_W  = 32;

	localparam int DIV_W     = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int INV_NUM_BIT = 47;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KAPPA           = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_ORIENTATION = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIGMA       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIGMA       = 8'd3;

	localparam logic [15:0] KAPPA_RESET     = 16'd12288;
	localparam logic        USE_ORI_RESET   = 1'b1;
	localparam logic [15:0] MIN_SIGMA_RESET = 16'd256;
	localparam logic [15:0] MAX_SIGMA_RESET = 16'd65535;

	localparam logic CMD_STATS    = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	localparam logic [FLAG_W-1:0] ONE_Q15 = 16'd32768;
	localparam int ONE_DOT = 1 << (2 * FRAC_BITS);
	localparam int Q15_SHIFT = 15;
	localparam int WARN_SHIFT = 14;

	typedef struct packed {
		logic [15:0] kappa;
		logic        use_orientation;
		logic [15:0] min_sigma;
		logic [15:0] max_sigma;
	} cuw_cfg_t;

	typedef struct packed {
		logic              command;
		logic              last_element;
		logic [FLAG_W-1:0] flag;
		logic [D2_W-1:0]   d2;
		logic [FLAG_W-1:0] orient;
	} cuw_entry_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} cuw_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} cuw_div_rsp_t;

	typedef logic [15:0] cuw_table_t [EXP_TABLE_ENTRIES];

	function automatic logic signed [COMPONENT_BITS-1:0] component(
		input logic [FIELD_W-1:0] packed_word, input int idx);
		return packed_word[idx*COMPONENT_BITS +: COMPONENT_BITS];
	endfunction

	// Logistic weight at the midpoint of one table interval. exp(-a) comes
	// from a cubic series at a/256 followed by eight truncated squarings.
	function automatic logic [15:0] logistic_entry(input int unsigned idx);
		logic [63:0] a;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] y3;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		logic [15:0] q;
		a  = ((64'(2 * idx) + 64'd1) << 19) / EXP_TABLE_ENTRIES;
		y  = a << 8;
		y2 = (y * y) >> 32;
		y3 = (y2 * y) >> 32;
		e  = (64'd1 << 32) - y + (y2 >> 1) - y3 / 64'd6;
		for (int k = 0; k < 8; k++) begin
			if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
			e = (e * e) >> 32;
		end
		d   = (64'd1 << 32) + e;
		num = e * 64'd32768 + (d >> 1);
		q   = '0;
		for (int b = 15; b >= 0; b--) begin
			if (num >= (d << b)) begin
				num  = num - (d << b);
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic cuw_table_t build_logistic();
		cuw_table_t t;
		for (int i = 0; i < EXP_TABLE_ENTRIES; i++) t[i] = logistic_entry(i);
		return t;
	endfunction

	localparam cuw_table_t LOGISTIC = build_logistic();

endpackage

`default_nettype wire

[hw/rtl/cuw_channels.sv]
// ----------------------------------------------------------------------------
// cuw_channels: handshake channels of the inlier weighting block
// Input pair words, result words and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cuw_item_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [cuw_pkg::FIELD_W-1:0] float_position;
	logic [cuw_pkg::FIELD_W-1:0] float_normal;
	logic [cuw_pkg::FIELD_W-1:0] match_position;
	logic [cuw_pkg::FIELD_W-1:0] match_normal;
	logic [cuw_pkg::FLAG_W-1:0]  match_flag;
	logic                        last_element;

	modport source (output valid, command, float_position, float_normal,
		match_position, match_normal, match_flag, last_element, input ready);
	modport sink (input valid, command, float_position, float_normal,
		match_position, match_normal, match_flag, last_element, output ready);
endinterface

interface cuw_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] probability;
	logic        normal_warning;
	logic        last_result;

	modport source (output valid, probability, normal_warning, last_result,
		input ready);
	modport sink (input valid, probability, normal_warning, last_result,
		output ready);
endinterface

interface cuw_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cuw_pkg::CFG_IDX_W-1:0]  index;
	logic [cuw_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/cuw_fifo.sv]
// ----------------------------------------------------------------------------
// cuw_fifo: short queue between the front and the back
// Holds prepared pair entries so that either side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cuw_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  cuw_pkg::cuw_entry_t      push_data,
	output logic                     full,
	input  wire logic                pop,
	output cuw_pkg::cuw_entry_t      head,
	output logic                     empty
);

	cuw_pkg::cuw_entry_t slot_q [cuw_pkg::QUEUE_DEPTH];
	logic [cuw_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [cuw_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [cuw_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full  = (count_q == cuw_pkg::QUEUE_CNT_W'(cuw_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cuw_pkg::QUEUE_CNT_W'(cuw_pkg::QUEUE_DEPTH))
		else $error("queue fill count out of range");

endmodule

`default_nettype wire

[hw/rtl/cuw_div.sv]
// ----------------------------------------------------------------------------
// cuw_div: iterative unsigned divider, one quotient bit per cycle
// Restoring division of a 64-bit dividend by a non-zero 64-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cuw_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  cuw_pkg::cuw_div_req_t req,
	output cuw_pkg::cuw_div_rsp_t rsp
);

	localparam int W = cuw_pkg::DIV_W;

	logic [W:0]                       rem_q;
	logic [W-1:0]                     quo_q;
	logic [W-1:0]                     divisor_q;
	logic [cuw_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [W:0]                       trial;
	logic                             fits;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cuw_pkg::DIV_CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cuw_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, divisor_q} : trial;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[hw/rtl/cuw_front.sv]
// ----------------------------------------------------------------------------
// cuw_front: input side, turns one pair word into a queue entry
// Clamps the flag, forms the squared six-dimensional distance and the
// orientation weight of the normals.
// ----------------------------------------------------------------------------
`default_nettype none

module cuw_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	cuw_item_if.sink            items,
	output logic                push,
	output cuw_pkg::cuw_entry_t push_data,
	input  wire logic           full
);

	localparam int CB = cuw_pkg::COMPONENT_BITS;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_PUSH} f_state_t;

	f_state_t                          state_q;
	logic                              cmd_q;
	logic                              last_q;
	logic [cuw_pkg::FLAG_W-1:0]        flag_q;
	logic [cuw_pkg::FIELD_W-1:0]       fp_q, fn_q, mp_q, mn_q;
	logic [cuw_pkg::SQ_W-1:0]          sqp_q [3];
	logic [cuw_pkg::SQ_W-1:0]          sqn_q [3];
	logic signed [2*CB-1:0]            dotp_q [3];
	cuw_pkg::cuw_entry_t               entry_q;

	logic [cuw_pkg::SQ_W-1:0]          sqp [3];
	logic [cuw_pkg::SQ_W-1:0]          sqn [3];
	logic signed [2*CB-1:0]            dotp [3];
	logic [cuw_pkg::D2_W-1:0]          d2;
	logic signed [cuw_pkg::DOT_W-1:0]  dot_t;
	logic [cuw_pkg::DOT_W-1:0]         quarter;
	logic [cuw_pkg::FLAG_W-1:0]        orient;

	// One lane per axis: squared differences and normal products.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [cuw_pkg::DIFF_W-1:0] dp;
			logic signed [cuw_pkg::DIFF_W-1:0] dn;
			logic signed [2*cuw_pkg::DIFF_W-1:0] p2;
			logic signed [2*cuw_pkg::DIFF_W-1:0] n2;
			dp = cuw_pkg::DIFF_W'(cuw_pkg::component(mp_q, i))
				- cuw_pkg::DIFF_W'(cuw_pkg::component(fp_q, i));
			dn = cuw_pkg::DIFF_W'(cuw_pkg::component(mn_q, i))
				- cuw_pkg::DIFF_W'(cuw_pkg::component(fn_q, i));
			p2 = dp * dp;
			n2 = dn * dn;
			sqp[i]  = p2[cuw_pkg::SQ_W-1:0];
			sqn[i]  = n2[cuw_pkg::SQ_W-1:0];
			dotp[i] = cuw_pkg::component(fn_q, i) * cuw_pkg::component(mn_q, i);
		end
	end

	always_comb begin
		d2 = '0;
		dot_t = cuw_pkg::DOT_W'(cuw_pkg::ONE_DOT);
		for (int i = 0; i < 3; i++) begin
			d2 = d2 + cuw_pkg::D2_W'(sqp_q[i]) + cuw_pkg::D2_W'(sqn_q[i]);
			dot_t = dot_t + cuw_pkg::DOT_W'(dotp_q[i]);
		end
		quarter = cuw_pkg::DOT_W'($unsigned(dot_t) >> 2);
		if (dot_t[cuw_pkg::DOT_W-1]) orient = '0;
		else if (quarter > cuw_pkg::DOT_W'(cuw_pkg::ONE_Q15)) orient = cuw_pkg::ONE_Q15;
		else orient = quarter[cuw_pkg::FLAG_W-1:0];
	end

	assign items.ready = (state_q == F_IDLE);
	assign push        = (state_q == F_PUSH) && !full;
	assign push_data   = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (items.valid) state_q <= F_MUL;
				F_MUL: state_q <= F_SUM;
				F_SUM: state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && items.valid) begin
			cmd_q  <= items.command;
			last_q <= items.last_element;
			flag_q <= (items.match_flag > cuw_pkg::ONE_Q15) ? cuw_pkg::ONE_Q15
				: items.match_flag;
			fp_q   <= items.float_position;
			fn_q   <= items.float_normal;
			mp_q   <= items.match_position;
			mn_q   <= items.match_normal;
		end
		if (state_q == F_MUL) begin
			sqp_q  <= sqp;
			sqn_q  <= sqn;
			dotp_q <= dotp;
		end
		if (state_q == F_SUM) begin
			entry_q.command      <= cmd_q;
			entry_q.last_element <= last_q;
			entry_q.flag         <= flag_q;
			entry_q.d2           <= d2;
			entry_q.orient       <= orient;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/cuw_back.sv]
// ----------------------------------------------------------------------------
// cuw_back: execution side, statistics and classification of entries
// Keeps the pass sums, derives the inverse of sigma squared with the shared
// divider and produces the weighted inlier probability.
// ----------------------------------------------------------------------------
`default_nettype none

module cuw_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  cuw_pkg::cuw_cfg_t   cfg,
	input  cuw_pkg::cuw_entry_t head,
	input  wire logic           empty,
	output logic                pop,
	cuw_result_if.source        results
);

	typedef enum logic [3:0] {
		B_IDLE, B_ST_MUL, B_ST_ACC, B_ST_DIV, B_ST_DIV1W, B_ST_INV, B_ST_DIV2W,
		B_CL_MUL, B_CL_SUM, B_CL_MAG, B_CL_PROB, B_CL_OUT
	} b_state_t;

	b_state_t                          state_q;
	cuw_pkg::cuw_entry_t               ent_q;
	logic [cuw_pkg::PROD_W-1:0]        prod_q;
	logic [cuw_pkg::LIM_W-1:0]         lo_q, hi_q, s2_q;
	logic [cuw_pkg::SUM_W-1:0]         wds_q;
	logic [cuw_pkg::WT_W-1:0]          wt_q;
	logic [cuw_pkg::INV_W-1:0]         inv_q;
	logic [cuw_pkg::CNT_W-1:0]         ec_q;
	logic [cuw_pkg::ORI_W-1:0]         ot_q;
	logic [cuw_pkg::PP_W-1:0]          pplo_q, pphi_q;
	logic [cuw_pkg::K2_W-1:0]          k2_q;
	logic [cuw_pkg::Z_W-1:0]           z_q;
	logic                              ovf_q;
	logic [15:0]                       weight_q;
	logic [15:0]                       p1_q;
	logic                              out_valid_q;
	logic [15:0]                       prob_q;
	logic                              warn_q;
	logic                              last_q;

	cuw_pkg::cuw_div_req_t             div_req;
	cuw_pkg::cuw_div_rsp_t             div_rsp;

	logic [cuw_pkg::SUM_W:0]           wds_sum;
	logic [cuw_pkg::WT_W:0]            wt_sum;
	logic [cuw_pkg::LIM_W-1:0]         s2_clamp;
	logic [cuw_pkg::ZP_W-1:0]          zprod;
	logic                              neg;
	logic [cuw_pkg::Z_W-1:0]           zdiff;
	logic [cuw_pkg::MAG_W-1:0]         mag;
	logic [15:0]                       entry_w;
	logic [2*cuw_pkg::FLAG_W-1:0]      p1_full, p2_full;
	logic [15:0]                       p2;
	logic [cuw_pkg::ORI_W:0]           ot_sum;
	logic [cuw_pkg::ORI_W-1:0]         ot_next;
	logic [cuw_pkg::CNT_W-1:0]         ec_next;
	logic                              warn;
	logic                              out_free;

	cuw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		div_req.start = ((state_q == B_ST_DIV) && (wt_q != '0))
			|| ((state_q == B_ST_INV) && (s2_q != '0));
		if (state_q == B_ST_INV) begin
			div_req.dividend = cuw_pkg::DIV_W'(1) << cuw_pkg::INV_NUM_BIT;
			div_req.divisor  = cuw_pkg::DIV_W'(s2_q);
		end else begin
			div_req.dividend = wds_q;
			div_req.divisor  = cuw_pkg::DIV_W'(wt_q);
		end
	end

	// Statistics side: saturating sums and the clamped variance.
	assign wds_sum = {1'b0, wds_q} + (cuw_pkg::SUM_W + 1)'(prod_q);
	assign wt_sum  = {1'b0, wt_q} + (cuw_pkg::WT_W + 1)'(ent_q.flag);

	always_comb begin
		if (div_rsp.quotient < cuw_pkg::DIV_W'(lo_q)) s2_clamp = lo_q;
		else if (div_rsp.quotient > cuw_pkg::DIV_W'(hi_q)) s2_clamp = hi_q;
		else s2_clamp = div_rsp.quotient[cuw_pkg::LIM_W-1:0];
	end

	// Classify side: scaled distance against kappa squared, then the table.
	assign zprod = cuw_pkg::ZP_W'(pplo_q)
		+ (cuw_pkg::ZP_W'(pphi_q) << cuw_pkg::HALF_W);

	always_comb begin
		neg   = !ovf_q && (z_q < cuw_pkg::Z_W'(k2_q));
		zdiff = neg ? cuw_pkg::Z_W'(k2_q) - z_q : z_q - cuw_pkg::Z_W'(k2_q);
		mag   = zdiff[cuw_pkg::Z_W-1:1];
		if (ovf_q || (mag[cuw_pkg::MAG_W-1:cuw_pkg::ARG_W] != '0)) entry_w = '0;
		else entry_w = cuw_pkg::LOGISTIC[
			mag[cuw_pkg::ARG_W-1:cuw_pkg::ARG_W-cuw_pkg::EXP_IDX_W]];
	end

	assign p1_full = ent_q.flag * weight_q;
	assign p2_full = p1_q * ent_q.orient;
	assign p2 = cfg.use_orientation ? p2_full[cuw_pkg::Q15_SHIFT +: 16] : p1_q;

	assign ot_sum  = {1'b0, ot_q} + (cuw_pkg::ORI_W + 1)'(ent_q.orient);
	assign ot_next = ot_sum[cuw_pkg::ORI_W] ? '1 : ot_sum[cuw_pkg::ORI_W-1:0];
	assign ec_next = (ec_q == '1) ? ec_q : ec_q + 1'b1;
	assign warn = ent_q.last_element && cfg.use_orientation
		&& ((cuw_pkg::ORI_W + 1)'(ot_next)
			< ((cuw_pkg::ORI_W + 1)'(ec_next) << cuw_pkg::WARN_SHIFT));

	assign out_free = !out_valid_q || results.ready;
	assign pop = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			wds_q       <= '0;
			wt_q        <= '0;
			inv_q       <= '0;
			ec_q        <= '0;
			ot_q        <= '0;
			out_valid_q <= 1'b0;
			prob_q      <= '0;
			warn_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// A word that leaves while the next one is loaded is replaced below.
			if (out_valid_q && results.ready && (state_q != B_CL_OUT))
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= (head.command == cuw_pkg::CMD_CLASSIFY)
							? B_CL_MUL : B_ST_MUL;
					end
				end
				B_ST_MUL: state_q <= B_ST_ACC;
				B_ST_ACC: begin
					wds_q   <= wds_sum[cuw_pkg::SUM_W] ? '1 : wds_sum[cuw_pkg::SUM_W-1:0];
					wt_q    <= wt_sum[cuw_pkg::WT_W] ? '1 : wt_sum[cuw_pkg::WT_W-1:0];
					state_q <= ent_q.last_element ? B_ST_DIV : B_IDLE;
				end
				B_ST_DIV: state_q <= (wt_q == '0) ? B_ST_INV : B_ST_DIV1W;
				B_ST_DIV1W: if (div_rsp.done) state_q <= B_ST_INV;
				B_ST_INV: begin
					if (s2_q == '0) begin
						inv_q   <= '1;
						wds_q   <= '0;
						wt_q    <= '0;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_ST_DIV2W;
					end
				end
				B_ST_DIV2W: begin
					if (div_rsp.done) begin
						inv_q <= (div_rsp.quotient[cuw_pkg::DIV_W-1:cuw_pkg::INV_W] != '0)
							? '1 : div_rsp.quotient[cuw_pkg::INV_W-1:0];
						wds_q   <= '0;
						wt_q    <= '0;
						state_q <= B_IDLE;
					end
				end
				B_CL_MUL: state_q <= B_CL_SUM;
				B_CL_SUM: state_q <= B_CL_MAG;
				B_CL_MAG: state_q <= B_CL_PROB;
				B_CL_PROB: state_q <= B_CL_OUT;
				B_CL_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						prob_q      <= p2;
						warn_q      <= warn;
						last_q      <= ent_q.last_element;
						ot_q        <= ent_q.last_element ? '0 : ot_next;
						ec_q        <= ent_q.last_element ? '0 : ec_next;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
		if (state_q == B_ST_MUL) begin
			prod_q <= cuw_pkg::PROD_W'(ent_q.d2) * cuw_pkg::PROD_W'(ent_q.flag);
			lo_q   <= cuw_pkg::LIM_W'(cfg.min_sigma) * cuw_pkg::LIM_W'(cfg.min_sigma);
			hi_q   <= cuw_pkg::LIM_W'(cfg.max_sigma) * cuw_pkg::LIM_W'(cfg.max_sigma);
		end
		if (state_q == B_ST_DIV && wt_q == '0) s2_q <= hi_q;
		if (state_q == B_ST_DIV1W && div_rsp.done) s2_q <= s2_clamp;
		if (state_q == B_CL_MUL) begin
			pplo_q <= cuw_pkg::PP_W'(ent_q.d2)
				* cuw_pkg::PP_W'(inv_q[cuw_pkg::HALF_W-1:0]);
			pphi_q <= cuw_pkg::PP_W'(ent_q.d2)
				* cuw_pkg::PP_W'(inv_q[cuw_pkg::INV_W-1:cuw_pkg::HALF_W]);
			k2_q   <= 24'((32'(cfg.kappa) * 32'(cfg.kappa)) >> cuw_pkg::FRAC_BITS);
		end
		if (state_q == B_CL_SUM) begin
			ovf_q <= (zprod[cuw_pkg::ZP_W-1:cuw_pkg::SUM_W] != '0);
			z_q   <= zprod[cuw_pkg::SUM_W-1:cuw_pkg::Z_SHIFT];
		end
		if (state_q == B_CL_MAG) weight_q <= neg ? cuw_pkg::ONE_Q15 - entry_w : entry_w;
		if (state_q == B_CL_PROB) p1_q <= p1_full[cuw_pkg::Q15_SHIFT +: 16];
	end

	assign results.valid          = out_valid_q;
	assign results.probability    = prob_q;
	assign results.normal_warning = warn_q;
	assign results.last_result    = last_q;

	a_warn_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && warn_q) |-> last_q)
		else $error("orientation warning on a result that is not the last");
	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready)
		|=> (out_valid_q && $stable(prob_q) && $stable(last_q)))
		else $error("stalled result word changed");

endmodule

`default_nettype wire

[hw/rtl/correspondence_inlier_weighting.sv]
// ----------------------------------------------------------------------------
// correspondence_inlier_weighting: inlier weights of matched point pairs
// Two passes over a pair stream: statistics, then per-pair inlier weight.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word
//   items     in         command, four packed 3D vectors, flag, last marker
//   results   out        probability, normal_warning, last_result
//   cfg       in         register index and 16-bit data (always ready)
//
// The front runs each word through its multiply, sum and push states; the
// back needs fewer states for a statistics word and more for a classify word,
// so the front sets the rate of the statistics pass and the back that of the
// classify pass. The last statistics word adds up to two 64-bit divisions.
// Reset clears all sums, counters and the inverse of sigma squared at once;
// there is no clearing pass.
// A stalled result stays in the output register; the back then waits and the
// queue of 4 entries lets the front keep accepting until it fills.
`default_nettype none

module correspondence_inlier_weighting (
	input wire logic      clk,
	input wire logic      arst_n,
	cuw_item_if.sink      items,
	cuw_result_if.source  results,
	cuw_cfg_if.sink       cfg
);

	// Register file. Writes are taken at any time; indexes beyond the list
	// are dropped.
	cuw_pkg::cuw_cfg_t   cfg_q;
	cuw_pkg::cuw_entry_t push_data;
	cuw_pkg::cuw_entry_t head;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kappa           <= cuw_pkg::KAPPA_RESET;
			cfg_q.use_orientation <= cuw_pkg::USE_ORI_RESET;
			cfg_q.min_sigma       <= cuw_pkg::MIN_SIGMA_RESET;
			cfg_q.max_sigma       <= cuw_pkg::MAX_SIGMA_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				cuw_pkg::REG_KAPPA:           cfg_q.kappa <= cfg.data;
				cuw_pkg::REG_USE_ORIENTATION: cfg_q.use_orientation <= cfg.data[0];
				cuw_pkg::REG_MIN_SIGMA:       cfg_q.min_sigma <= cfg.data;
				cuw_pkg::REG_MAX_SIGMA:       cfg_q.max_sigma <= cfg.data;
				default: ;
			endcase
		end
	end

	// The front prepares distance and orientation weight of each pair.
	cuw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// The queue decouples preparation from the pass arithmetic.
	cuw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// The back keeps the sums, the sigma estimate and the result register.
	cuw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire

[tb/cuw_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuw_scoreboard: prediction and comparison for correspondence inlier weighting
// Watches the pair, result and register channels, keeps its own copy of the
// block's state, and checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cuw_scoreboard (
	input wire logic clk,
	input wire logic arst_n,
	cuw_item_if      items,
	cuw_result_if    results,
	cuw_cfg_if       cfg,
	output int       errors,
	output int       pending
);
	import cuw_pkg::*;

	typedef struct packed {
		logic [15:0] probability;
		logic        normal_warning;
		logic        last_result;
	} weight_word_t;

	logic [15:0] logistic_lut [EXP_TABLE_ENTRIES];
	logic [63:0] dist_sum;
	logic [63:0] flag_sum;
	logic [63:0] inv_s2;
	logic [63:0] pair_count;
	logic [63:0] orient_sum;
	cuw_cfg_t    regs;
	weight_word_t weights_due[$];

	// exp(-t) with t in 16 fraction bits, result in 32 fraction bits.
	function automatic logic [63:0] decay(input logic [63:0] t);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] y3;
		logic [63:0] e;
		y  = t << 8;
		y2 = (y * y) >> 32;
		y3 = (y2 * y) >> 32;
		e  = (64'd1 << 32) - y + (y2 >> 1) - y3 / 64'd6;
		for (int k = 0; k < 8; k++) begin
			if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
			e = (e * e) >> 32;
		end
		return e;
	endfunction

	initial begin
		logic [63:0] a;
		logic [63:0] e;
		logic [63:0] d;
		for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
			a = ((64'(2 * i) + 64'd1) << 19) / EXP_TABLE_ENTRIES;
			e = decay(a);
			d = (64'd1 << 32) + e;
			logistic_lut[i] = 16'((e * 64'd32768 + d / 2) / d);
		end
	end

	function automatic longint coord(input logic [47:0] v, input int idx);
		logic signed [15:0] c;
		c = v[idx*16 +: 16];
		return longint'(c);
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] lim);
		if (a > lim || b > lim - a) return lim;
		return a + b;
	endfunction

	localparam logic [63:0] LIM40 = (64'd1 << 40) - 1;
	localparam logic [63:0] CNT_LIM = (64'd1 << CNT_W) - 1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_sum   <= '0;
			flag_sum   <= '0;
			inv_s2     <= '0;
			pair_count <= '0;
			orient_sum <= '0;
			regs       <= {KAPPA_RESET, USE_ORI_RESET, MIN_SIGMA_RESET, MAX_SIGMA_RESET};
			errors     <= 0;
			pending    <= 0;
			weights_due.delete();
		end else begin
			automatic cuw_cfg_t     nregs = regs;
			automatic logic [63:0]  nsum = dist_sum, nflags = flag_sum, ninv = inv_s2;
			automatic logic [63:0]  ncount = pair_count, norient = orient_sum;
			automatic int           nerr = errors;
			automatic int           npend = pending;
			automatic weight_word_t got, want;
			automatic logic [63:0]  flag, d2, lo, hi, s2, z, k2, mag, wt, p, w;
			automatic logic [127:0] zp;
			automatic longint       dp, dn, dot;
			automatic logic         neg;

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_KAPPA:           nregs.kappa = cfg.data;
					REG_USE_ORIENTATION: nregs.use_orientation = cfg.data[0];
					REG_MIN_SIGMA:       nregs.min_sigma = cfg.data;
					REG_MAX_SIGMA:       nregs.max_sigma = cfg.data;
					default: ;
				endcase
			end

			if (items.valid && items.ready) begin
				flag = items.match_flag > ONE_Q15 ? 64'(ONE_Q15) : 64'(items.match_flag);
				d2 = '0;
				for (int i = 0; i < 3; i++) begin
					dp = coord(items.match_position, i) - coord(items.float_position, i);
					dn = coord(items.match_normal, i) - coord(items.float_normal, i);
					d2 += 64'(dp * dp) + 64'(dn * dn);
				end
				if (items.command == CMD_STATS) begin
					nsum   = add_sat(nsum, d2 * flag, '1);
					nflags = add_sat(nflags, flag, LIM40);
					if (items.last_element) begin
						lo = 64'(regs.min_sigma) * 64'(regs.min_sigma);
						hi = 64'(regs.max_sigma) * 64'(regs.max_sigma);
						if (nflags == 0) s2 = hi;
						else begin
							s2 = nsum / nflags;
							if (s2 < lo) s2 = lo;
							else if (s2 > hi) s2 = hi;
						end
						if (s2 == 0) ninv = 64'hFFFF_FFFF;
						else begin
							ninv = (64'd1 << 47) / s2;
							if (ninv > 64'hFFFF_FFFF) ninv = 64'hFFFF_FFFF;
						end
						nsum   = '0;
						nflags = '0;
					end
				end else begin
					zp  = 128'(d2) * 128'(inv_s2);
					z   = (zp[127:64] != 0) ? '1 : 64'(zp >> 31);
					k2  = (64'(regs.kappa) * 64'(regs.kappa)) >> 8;
					neg = z < k2;
					mag = neg ? (k2 - z) >> 1 : (z - k2) >> 1;
					wt  = (mag >= (64'd16 << 16)) ? 64'd0 : 64'(logistic_lut[mag >> 12]);
					if (neg) wt = 64'd32768 - wt;
					p = (flag * wt) >> 15;
					// Orientation agreement (n.n')/2 + 1/2, kept even when unused.
					dot = 0;
					for (int i = 0; i < 3; i++)
						dot += coord(items.float_normal, i) * coord(items.match_normal, i);
					dot += 65536;
					if (dot < 0) dot = 0;
					w = 64'(dot) >> 2;
					if (w > 64'd32768) w = 64'd32768;
					if (regs.use_orientation) p = (p * w) >> 15;
					norient = add_sat(norient, w, LIM40);
					ncount  = add_sat(ncount, 64'd1, CNT_LIM);
					want.probability    = p[15:0];
					want.normal_warning = 1'b0;
					want.last_result    = items.last_element;
					if (items.last_element) begin
						want.normal_warning = regs.use_orientation && (norient < (ncount << 14));
						norient = '0;
						ncount  = '0;
					end
					weights_due.push_back(want);
					npend++;
				end
			end

			if (results.valid && results.ready) begin
				got = {results.probability, results.normal_warning, results.last_result};
				if (weights_due.size() == 0) begin
					nerr++;
					if (nerr <= 10)
						$display("unexpected result word: prob %0d warn %0b last %0b",
							got.probability, got.normal_warning, got.last_result);
				end else begin
					want = weights_due.pop_front();
					npend--;
					if (got !== want) begin
						nerr++;
						if (nerr <= 10)
							$display("mismatch: expected prob %0d warn %0b last %0b, got prob %0d warn %0b last %0b",
								want.probability, want.normal_warning, want.last_result,
								got.probability, got.normal_warning, got.last_result);
					end
				end
			end

			regs       <= nregs;
			dist_sum   <= nsum;
			flag_sum   <= nflags;
			inv_s2     <= ninv;
			pair_count <= ncount;
			orient_sum <= norient;
			errors     <= nerr;
			pending    <= npend;
		end
	end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for correspondence inlier weighting
// Streams point sets through the statistics and classify passes under a
// number of register settings, with bursty input and a stalling receiver,
// and leaves all checking to the scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import cuw_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	logic hold_req;
	int   burst_left;

	cuw_item_if   items ();
	cuw_result_if results ();
	cuw_cfg_if    cfg ();

	correspondence_inlier_weighting uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results),
		.cfg    (cfg)
	);

	cuw_scoreboard checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results),
		.cfg    (cfg),
		.errors (errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver. Its stall pattern is redrawn at random intervals: always
	// ready, random stalls, or mostly stalled. Once during the run a long
	// hold-off is requested so that the internal queue fills and the block
	// must stop taking pair words.
	initial begin
		int mode;
		int span;
		int hold;
		results.ready = 1'b0;
		mode = 0;
		span = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold == 0) hold = 400;
			if (span == 0) begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(10, 80);
			end
			span--;
			if (hold > 1) begin
				hold--;
				results.ready <= 1'b0;
			end else if (mode == 0) results.ready <= 1'b1;
			else if (mode == 1) results.ready <= ($urandom_range(0, 1) == 1);
			else results.ready <= ($urandom_range(0, 4) == 0);
		end
	end

	// One register write. The valid line is left high so that back-to-back
	// writes need no second assignment in the same step; see cfg_done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(negedge clk); while (!cfg.ready);
		@(posedge clk);
	endtask

	task automatic cfg_done();
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] kap, input logic ori,
		input logic [15:0] lo, input logic [15:0] hi);
		write_reg(REG_KAPPA, kap);
		write_reg(REG_USE_ORIENTATION, {15'd0, ori});
		write_reg(REG_MIN_SIGMA, lo);
		write_reg(REG_MAX_SIGMA, hi);
		cfg_done();
	endtask

	// Wait until every predicted word has come back, then let the pass-end
	// division settle before anything is reconfigured.
	task automatic drain();
		wait (pending == 0);
		repeat (300) @(posedge clk);
	endtask

	// Offer one pair word. The sender runs in bursts; between bursts valid
	// is dropped for a random gap.
	task automatic send_pair(input logic cmd, input logic [47:0] fp, input logic [47:0] fn,
		input logic [47:0] mp, input logic [47:0] mn, input logic [15:0] flag,
		input logic last);
		if (burst_left == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 10);
		end
		burst_left--;
		items.valid          <= 1'b1;
		items.command        <= cmd;
		items.float_position <= fp;
		items.float_normal   <= fn;
		items.match_position <= mp;
		items.match_normal   <= mn;
		items.match_flag     <= flag;
		items.last_element   <= last;
		do @(negedge clk); while (!items.ready);
		@(posedge clk);
	endtask

	function automatic logic [47:0] full_rand();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Offsets each coordinate of base by up to spread, wrapping at 16 bits.
	function automatic logic [47:0] near(input logic [47:0] base, input int spread);
		logic [47:0] v;
		for (int i = 0; i < 3; i++)
			v[i*16 +: 16] = base[i*16 +: 16] + 16'($urandom_range(0, 2 * spread) - spread);
		return v;
	endfunction

	function automatic logic [15:0] rand_flag();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return ONE_Q15;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// A point set streamed twice: statistics then classify, same content.
	// A few sets are broken up: stray commands or misplaced last markers.
	task automatic point_set(input int n);
		logic [47:0] fp [];
		logic [47:0] fn [];
		logic [47:0] mp [];
		logic [47:0] mn [];
		logic [15:0] fl [];
		logic        broken;
		int          spread;
		fp = new[n];
		fn = new[n];
		mp = new[n];
		mn = new[n];
		fl = new[n];
		broken = ($urandom_range(0, 9) == 0);
		spread = ($urandom_range(0, 3) == 0) ? 8000 : $urandom_range(1, 600);
		for (int i = 0; i < n; i++) begin
			fp[i] = ($urandom_range(0, 9) == 0) ? full_rand() : near(48'd0, 20000);
			mp[i] = ($urandom_range(0, 9) == 0) ? full_rand() : near(fp[i], spread);
			fn[i] = ($urandom_range(0, 9) == 0) ? full_rand() : near(48'd0, 256);
			mn[i] = ($urandom_range(0, 9) == 0) ? full_rand() : near(fn[i], 200);
			fl[i] = rand_flag();
		end
		for (int i = 0; i < n; i++)
			send_pair(broken ? 1'($urandom) : CMD_STATS, fp[i], fn[i], mp[i], mn[i], fl[i],
				broken ? ($urandom_range(0, 5) == 0) : (i == n - 1));
		if (!broken && $urandom_range(0, 3) == 0) hold_req <= 1'b1;
		for (int i = 0; i < n; i++)
			send_pair(CMD_CLASSIFY, fp[i], fn[i], mp[i], mn[i], fl[i], i == n - 1);
	endtask

	task automatic random_phase(input int quota);
		int sent;
		int n;
		sent = 0;
		while (sent < quota) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			point_set(n);
			sent += 2 * n;
		end
		items.valid <= 1'b0;
		burst_left = 0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		items.valid = 1'b0;
		items.command = CMD_STATS;
		items.float_position = '0;
		items.float_normal = '0;
		items.match_position = '0;
		items.match_normal = '0;
		items.match_flag = '0;
		items.last_element = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Classify before any statistics: the inverse is still zero.
		send_pair(CMD_CLASSIFY, 48'h7FFF_7FFF_7FFF, 48'h0100_0000_0000,
			48'h8000_8000_8000, 48'h0100_0000_0000, ONE_Q15, 1'b1);
		// Statistics with extreme coordinates and a flag above one.
		send_pair(CMD_STATS, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
			48'h8000_8000_8000, 48'h8000_8000_8000, 16'hFFFF, 1'b0);
		send_pair(CMD_STATS, 48'h0, 48'h0, 48'h0, 48'h0, 16'd0, 1'b0);
		send_pair(CMD_STATS, 48'h0000_0000_0100, 48'h0100_0000_0000,
			48'h0000_0000_0180, 48'h0100_0000_0000, ONE_Q15, 1'b1);
		// Classify: opposite normals (weight clamps to zero), aligned large
		// normals (clamps to one), zero distance, huge distance.
		send_pair(CMD_CLASSIFY, 48'h0, 48'h0000_0000_0100,
			48'h0, 48'h0000_0000_FF00, ONE_Q15, 1'b0);
		send_pair(CMD_CLASSIFY, 48'h0, 48'h7FFF_7FFF_7FFF,
			48'h0, 48'h7FFF_7FFF_7FFF, 16'hFFFF, 1'b0);
		send_pair(CMD_CLASSIFY, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
			48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, ONE_Q15, 1'b0);
		send_pair(CMD_CLASSIFY, 48'h0, 48'h0000_0000_FF00,
			48'h0, 48'h0000_0000_0100, 16'd0, 1'b1);
		// A zero flag sum: sigma squared becomes the upper limit.
		send_pair(CMD_STATS, 48'h1234_5678_9ABC, 48'h0, 48'h0, 48'h0, 16'd0, 1'b1);
		send_pair(CMD_CLASSIFY, 48'h1234_5678_9ABC, 48'h0, 48'h0, 48'h0, ONE_Q15, 1'b1);
		// Mixed commands: statistics continue across an interleaved classify.
		send_pair(CMD_STATS, 48'h0000_0000_0200, 48'h0, 48'h0, 48'h0, 16'd16384, 1'b0);
		send_pair(CMD_CLASSIFY, 48'h0000_0000_0200, 48'h0, 48'h0, 48'h0, 16'd16384, 1'b0);
		send_pair(CMD_STATS, 48'h0000_0300_0000, 48'h0, 48'h0, 48'h0, 16'd32767, 1'b1);
		send_pair(CMD_CLASSIFY, 48'h0000_0300_0000, 48'h0, 48'h0, 48'h0, 16'd1, 1'b1);
		items.valid <= 1'b0;
		drain();
		random_phase(150);

		// No orientation, kappa zero, no lower clamp.
		set_regs(16'd0, 1'b0, 16'd0, 16'hFFFF);
		random_phase(120);

		// Largest kappa and inverted limits: the lower clamp wins.
		set_regs(16'hFFFF, 1'b1, 16'hFFFF, 16'd0);
		random_phase(80);

		// Both limits zero: sigma squared is zero and the inverse saturates.
		set_regs(16'd4096, 1'b1, 16'd0, 16'd0);
		random_phase(80);

		// Tight upper limit, random kappa, an ignored register index.
		set_regs(16'($urandom), 1'b0, 16'd1, 16'd64);
		write_reg(8'd7, 16'hFFFF);
		cfg_done();
		random_phase(80);

		for (int ph = 0; ph < 3; ph++) begin
			set_regs(16'($urandom_range(0, 32768)), 1'($urandom),
				16'($urandom_range(0, 1024)), 16'($urandom_range(256, 65535)));
			random_phase(100);
		end

		if (errors == 0 && pending == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
